>>> sv/bpa_pkg.sv
// ---------------------------------------------------------------------------
// bpa_pkg
// Shared types, sizes and helper functions of the bitmap page allocator.
// ---------------------------------------------------------------------------
package bpa_pkg;

    // map geometry; page size is a power of two
    localparam int MAP_WORDS  = 1024;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WORD_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    // page numbers from a 32-bit address, one spare bit for region ends
    localparam int PG_W = 32 - PAGE_SHIFT;
    localparam int PN_W = PG_W + 1;

    localparam longint unsigned MAP_PAGES  = longint'(MAP_WORDS) * longint'(WORD_BITS);
    localparam longint unsigned ADDR_PAGES = 64'h1_0000_0000 >> PAGE_SHIFT;
    localparam longint unsigned PAGE_LIMIT = (MAP_PAGES < ADDR_PAGES) ? MAP_PAGES : ADDR_PAGES;

    localparam logic [PN_W-1:0]     LIMIT_PN  = PN_W'(PAGE_LIMIT);
    localparam logic [WORD_W:0]     HINT_END  = (WORD_W + 1)'(MAP_WORDS);
    localparam logic [WORD_W-1:0]   WORD_LAST = WORD_W'(MAP_WORDS - 1);
    localparam logic [31:0]         ALL_USED  = 32'hffff_ffff;

    // free page counter
    localparam int COUNT_W   = 22;
    localparam int COUNT_MAX = 2097151;
    localparam int COUNT_MIN = -2097152;

    localparam int OUT_W = 56;

    typedef enum logic [1:0] {
        CMD_ALLOC       = 2'd0,
        CMD_FREE        = 2'd1,
        CMD_FREE_REGION = 2'd2,
        CMD_RESERVE     = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_WALK,
        S_M0_RD,
        S_M0_WR,
        S_RESP
    } t_state;

    function automatic logic [WORD_W-1:0] page_to_word(input logic [PN_W-1:0] p);
        logic [63:0] t;
        t = 64'(p) >> BIT_W;
        return t[WORD_W-1:0];
    endfunction

    // bits lo..hi of one map word
    function automatic logic [31:0] range_mask(input logic [BIT_W-1:0] lo,
                                               input logic [BIT_W-1:0] hi);
        logic [BIT_W-1:0] top;
        top = BIT_W'(WORD_BITS - 1) - hi;
        return (ALL_USED << lo) & (ALL_USED >> top);
    endfunction

    function automatic logic [BIT_W-1:0] lowest_zero(input logic [31:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic signed [COUNT_W-1:0] count_add(
        input logic signed [COUNT_W-1:0] c,
        input logic signed [31:0]        d
    );
        logic signed [31:0] s;
        s = 32'(c) + d;
        if (s > 32'(COUNT_MAX)) begin
            s = 32'(COUNT_MAX);
        end else if (s < 32'(COUNT_MIN)) begin
            s = 32'(COUNT_MIN);
        end
        return COUNT_W'(s);
    endfunction

endpackage

>>> sv/bpa_ram.sv
// ---------------------------------------------------------------------------
// bpa_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module bpa_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/bitmap_page_allocator_core.sv
// ---------------------------------------------------------------------------
// bitmap_page_allocator_core
// Physical page allocator: used-bit map in a RAM plus a saturating
// free-page counter, with allocate, free, free-region and reserve-region.
// ---------------------------------------------------------------------------
//  channel   dir  tdata (lsb first)                              tuser
//  s (cmd)   in   byte_addr[31:0], byte_len[63:32]               command[1:0]
//  m (rsp)   out  alloc_addr[31:0], success[32], out_of_range[33],
//                 free_count[55:34]                              -
//
//  after reset a clearing pass writes every map word to all used, with no
//  item taken. allocate reads one map word after another, starting from
//  the lowest word that may still hold a clear bit; region commands read
//  and write back each word touched, and free-region also marks page 0
//  used again. the map RAM read-modify-write loop sets the pace.
//  one item is worked at a time; its result waits in an output register, and
//  a new item is taken while that result is still unclaimed.
// ---------------------------------------------------------------------------
module bitmap_page_allocator_core
    import bpa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [63:0]      i_s_tdata,   // byte_addr, byte_len
    input  logic [1:0]       i_s_tuser,   // command
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata    // alloc_addr, success, out_of_range, free_count
);

    t_state                      r_state, n_state;
    logic [WORD_W-1:0]           r_clr_ptr, n_clr_ptr;
    t_cmd                        r_cmd, n_cmd;
    logic [PN_W-1:0]             r_first, n_first;
    logic [PN_W-1:0]             r_stop, n_stop;
    logic                        r_oor, n_oor;
    logic [PN_W-1:0]             r_nmark, n_nmark;
    logic [WORD_W-1:0]           r_first_word, n_first_word;
    logic [WORD_W-1:0]           r_last_word, n_last_word;
    logic [BIT_W-1:0]            r_last_bit, n_last_bit;
    logic signed [COUNT_W-1:0]   r_free_count, n_free_count;
    logic [WORD_W:0]             r_hint, n_hint;
    logic [WORD_W:0]             r_rd_ptr, n_rd_ptr;
    logic [WORD_W-1:0]           r_chk_ptr, n_chk_ptr;
    logic                        r_pend, n_pend;
    logic [31:0]                 r_alloc_addr, n_alloc_addr;
    logic                        r_ok, n_ok;
    logic                        r_out_valid, n_out_valid;
    logic [OUT_W-1:0]            r_out_data, n_out_data;

    logic                        ram_we, ram_re;
    logic [WORD_W-1:0]           ram_waddr, ram_raddr;
    logic [31:0]                 ram_wdata, ram_rdata;

    logic [PN_W-1:0]             acc_first, acc_npg, acc_last;
    logic [PN_W-1:0]             stop_m1;
    logic [BIT_W-1:0]            hit_bit, lo_bit, hi_bit;
    logic [63:0]                 hit_page;
    logic [31:0]                 walk_mask;
    logic signed [31:0]          mark_mag;

    bpa_ram #(
        .W     (32),
        .DEPTH (MAP_WORDS),
        .AW    (WORD_W)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // region bounds as seen at the input
    assign acc_first = PN_W'(i_s_tdata[31:0] >> PAGE_SHIFT);
    assign acc_npg   = (t_cmd'(i_s_tuser) == CMD_FREE) ? PN_W'(1)
                                                      : PN_W'(i_s_tdata[63:32] >> PAGE_SHIFT);
    assign acc_last  = acc_first + acc_npg;
    assign stop_m1   = r_stop - PN_W'(1);

    assign hit_bit   = lowest_zero(ram_rdata);
    assign hit_page  = (64'(r_chk_ptr) << BIT_W) | 64'(hit_bit);

    assign lo_bit    = (r_chk_ptr == r_first_word) ? r_first[BIT_W-1:0] : '0;
    assign hi_bit    = (r_chk_ptr == r_last_word) ? r_last_bit : BIT_W'(WORD_BITS - 1);
    assign walk_mask = range_mask(lo_bit, hi_bit);
    assign mark_mag  = signed'(32'(r_nmark));

    always_comb begin
        n_state      = r_state;
        n_clr_ptr    = r_clr_ptr;
        n_cmd        = r_cmd;
        n_first      = r_first;
        n_stop       = r_stop;
        n_oor        = r_oor;
        n_nmark      = r_nmark;
        n_first_word = r_first_word;
        n_last_word  = r_last_word;
        n_last_bit   = r_last_bit;
        n_free_count = r_free_count;
        n_hint       = r_hint;
        n_rd_ptr     = r_rd_ptr;
        n_chk_ptr    = r_chk_ptr;
        n_pend       = 1'b0;
        n_alloc_addr = r_alloc_addr;
        n_ok         = r_ok;
        n_out_data   = r_out_data;
        n_out_valid  = r_out_valid & ~i_m_tready;

        ram_we    = 1'b0;
        ram_waddr = r_chk_ptr;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = r_rd_ptr[WORD_W-1:0];

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_ptr;
                ram_wdata = ALL_USED;
                n_clr_ptr = r_clr_ptr + WORD_W'(1);
                if (r_clr_ptr == WORD_LAST) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd   = t_cmd'(i_s_tuser);
                    n_first = acc_first;
                    n_stop  = (acc_last < LIMIT_PN) ? acc_last : LIMIT_PN;
                    n_oor   = (acc_npg != '0) && (acc_last > LIMIT_PN);
                    n_state = S_PREP;
                end
            end

            S_PREP: begin
                n_alloc_addr = '0;
                n_ok         = 1'b1;
                n_rd_ptr     = {1'b0, page_to_word(r_first)};
                n_first_word = page_to_word(r_first);
                n_last_word  = page_to_word(stop_m1);
                n_last_bit   = stop_m1[BIT_W-1:0];
                n_nmark      = r_stop - r_first;
                if (r_cmd == CMD_ALLOC) begin
                    n_rd_ptr = r_hint;
                    if ((r_free_count > 0) && (r_hint < HINT_END)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_ok    = 1'b0;
                        n_state = S_RESP;
                    end
                end else if (r_stop > r_first) begin
                    // freed pages may sit below the lowest known free word
                    if ((r_cmd != CMD_RESERVE) && ({1'b0, page_to_word(r_first)} < r_hint)) begin
                        n_hint = {1'b0, page_to_word(r_first)};
                    end
                    n_state = S_WALK;
                end else if (r_cmd == CMD_FREE_REGION) begin
                    n_state = S_M0_RD;
                end else begin
                    n_state = S_RESP;
                end
            end

            S_SCAN: begin
                ram_re = (r_rd_ptr < HINT_END);
                if (ram_re) begin
                    n_rd_ptr  = r_rd_ptr + (WORD_W + 1)'(1);
                    n_chk_ptr = r_rd_ptr[WORD_W-1:0];
                end
                n_pend = ram_re;
                if (r_pend) begin
                    if (ram_rdata != ALL_USED) begin
                        n_pend  = 1'b0;
                        n_state = S_RESP;
                        if (hit_page < PAGE_LIMIT) begin
                            ram_we       = 1'b1;
                            ram_wdata    = ram_rdata | (32'd1 << hit_bit);
                            n_free_count = count_add(r_free_count, -32'sd1);
                            n_hint       = {1'b0, r_chk_ptr};
                            n_alloc_addr = 32'(hit_page << PAGE_SHIFT);
                        end else begin
                            n_ok = 1'b0;
                        end
                    end else if (r_chk_ptr == WORD_LAST) begin
                        // nothing clear from the hint up: the map is full
                        n_ok    = 1'b0;
                        n_hint  = HINT_END;
                        n_state = S_RESP;
                    end
                end
            end

            S_WALK: begin
                ram_re = (r_rd_ptr <= {1'b0, r_last_word});
                if (ram_re) begin
                    n_rd_ptr  = r_rd_ptr + (WORD_W + 1)'(1);
                    n_chk_ptr = r_rd_ptr[WORD_W-1:0];
                end
                n_pend = ram_re;
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_wdata = (r_cmd == CMD_RESERVE) ? (ram_rdata | walk_mask)
                                                       : (ram_rdata & ~walk_mask);
                    if (r_chk_ptr == r_last_word) begin
                        // every mark moves the count, so the whole run goes at once
                        n_free_count = count_add(r_free_count,
                                                 (r_cmd == CMD_RESERVE) ? -mark_mag : mark_mag);
                        n_state = (r_cmd == CMD_FREE_REGION) ? S_M0_RD : S_RESP;
                    end
                end
            end

            S_M0_RD: begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                n_state   = S_M0_WR;
            end

            S_M0_WR: begin
                ram_we       = 1'b1;
                ram_waddr    = '0;
                ram_wdata    = ram_rdata | 32'd1;
                n_free_count = count_add(r_free_count, -32'sd1);
                n_state      = S_RESP;
            end

            S_RESP: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_free_count,
                                   (r_cmd != CMD_ALLOC) && r_oor,
                                   r_ok,
                                   r_alloc_addr};
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_ptr    <= '0;
            r_free_count <= '0;
            r_hint       <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_ptr    <= n_clr_ptr;
            r_free_count <= n_free_count;
            r_hint       <= n_hint;
            r_pend       <= n_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_first      <= n_first;
        r_stop       <= n_stop;
        r_oor        <= n_oor;
        r_nmark      <= n_nmark;
        r_first_word <= n_first_word;
        r_last_word  <= n_last_word;
        r_last_bit   <= n_last_bit;
        r_rd_ptr     <= n_rd_ptr;
        r_chk_ptr    <= n_chk_ptr;
        r_alloc_addr <= n_alloc_addr;
        r_ok         <= n_ok;
        r_out_data   <= n_out_data;
    end

endmodule
